// ----- hdl/i2cm_pkg.sv -----
// Shared types and constants for the I2C master register access block.
`default_nettype none

package i2cm_pkg;

  // Write buffer geometry
  localparam int WRITE_BUFFER_DEPTH = 16;
  localparam int BUF_IDX_W  = $clog2(WRITE_BUFFER_DEPTH);
  localparam int BUF_FILL_W = $clog2(WRITE_BUFFER_DEPTH + 1);

  // Item opcodes carried on the input tuser
  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_PUSH     = 3'd1,
    MODE_WRITE    = 3'd2,
    MODE_REG_READ = 3'd3,
    MODE_CUR_READ = 3'd4
  } mode_t;

  // Bus sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_START      = 5'd1,
    PH_SEND_ADDRW = 5'd2,
    PH_SEND_REG   = 5'd3,
    PH_SEND_DATA  = 5'd4,
    PH_SEND_ADDRR = 5'd5,
    PH_RSTART     = 5'd6,
    PH_RECV       = 5'd7,
    PH_STOP_OK    = 5'd8,
    PH_STOP_ERR   = 5'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_REG_READ = 2'd2,
    KIND_CUR_READ = 2'd3
  } kind_t;

  // R/W bit handling on the address byte
  localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
  localparam logic [7:0] ADDR_RD_BIT  = 8'h01;
  localparam logic [7:0] BYTE_MSB     = 8'h80;

  // One input item
  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [4:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
  } item_t;

  // One result item
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       done_res;
    logic       status;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/i2c_master_register_access_top.sv -----
// Top level of the I2C master register access block: stream ports and result buffering.
//
// Usage: every input item carries an opcode on in_tuser. A tick item advances the open-drain
// bus by one half-bit interval; push items fill the 16-byte write buffer while idle; start
// items launch a register write, a register read or a current-address read. Each accepted
// item yields exactly one result item showing SCL/SDA after that item, busy, any byte just
// received (read_last on out_tlast) and done/status when STOP completes.
// A result is registered in the output register, or the skid register while one waits.
// Throughput: one item per cycle while in_tready is high; the transaction state is
// updated by single-pass logic between the input handshake and the result register.
// Stall: a two-entry result buffer (output register plus skid register) lets one more item
// be accepted while a result waits; in_tready drops only while the skid register is full.
// Reset: rst_n (synchronous, active low) returns the bus to idle, empties the write buffer
// count and discards any pending results.
`default_nettype none

module i2c_master_register_access_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [6:0] device_address, [14:7] register_address, [19:15] byte_count,
  // [27:20] write_byte, [28] sda_in, [31:29] zero
  input  wire logic [31:0] in_tdata,
  // [2:0] mode
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] scl_level, [1] sda_level, [2] busy_res, [3] read_valid, [11:4] read_data,
  // [12] done_res, [13] status, [15:14] zero
  output logic [15:0]      out_tdata,
  // read_last
  output logic             out_tlast
);

  i2cm_pkg::item_t   item;
  i2cm_pkg::result_t res;
  i2cm_pkg::result_t out_data_r, skid_data_r;
  logic              out_valid_r, skid_valid_r;
  logic              in_acc, out_free;

  // Unpack the input item
  assign item.mode             = in_tuser;
  assign item.device_address   = in_tdata[6:0];
  assign item.register_address = in_tdata[14:7];
  assign item.byte_count       = in_tdata[19:15];
  assign item.write_byte       = in_tdata[27:20];
  assign item.sda_in           = in_tdata[28];

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  i2cm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .item   (item),
    .result (res)
  );

  // Result buffer valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r  <= skid_valid_r || in_acc;
        skid_valid_r <= 1'b0;
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (in_acc) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r.status, out_data_r.done_res, out_data_r.read_data,
                       out_data_r.read_valid, out_data_r.busy_res, out_data_r.sda_level,
                       out_data_r.scl_level};
  assign out_tlast  = out_data_r.read_last;

endmodule

`default_nettype wire

// ----- hdl/i2cm_core.sv -----
// Bus sequencer: transaction state, write buffer and per-item result logic.
`default_nettype none

module i2cm_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire i2cm_pkg::item_t   item,
  output i2cm_pkg::result_t      result
);

  i2cm_pkg::phase_t phase_r, phase_nxt;
  i2cm_pkg::kind_t  kind_r, kind_nxt;
  logic [1:0] sub_step_r, sub_step_nxt;
  logic [3:0] bit_index_r, bit_index_nxt;
  logic [4:0] byte_index_r, byte_index_nxt;
  logic [7:0] shift_byte_r, shift_byte_nxt;
  logic [6:0] tgt_addr_r, tgt_addr_nxt;
  logic [7:0] tgt_reg_r, tgt_reg_nxt;
  logic [4:0] read_total_r, read_total_nxt;
  logic [i2cm_pkg::BUF_FILL_W-1:0] write_fill_r, write_fill_nxt;
  logic [7:0] wr_store_r [i2cm_pkg::WRITE_BUFFER_DEPTH];
  logic       wr_en;

  logic       rd_valid, rd_last, done, stat;
  logic [7:0] rd_data;
  logic [7:0] bit_shifted;
  logic [7:0] recv_shifted;
  logic [5:0] byte_plus_cur, byte_plus_new;
  logic       last_cur, last_new;
  logic [7:0] store_word;
  logic       more_data;
  logic [4:0] bc_in;

  assign bit_shifted   = {shift_byte_r[6:0], 1'b0};
  assign recv_shifted  = {shift_byte_r[6:0], item.sda_in};
  assign byte_plus_cur = {1'b0, byte_index_r} + 6'd1;
  assign last_cur      = byte_plus_cur >= {1'b0, read_total_r};
  assign store_word    = wr_store_r[byte_index_r[i2cm_pkg::BUF_IDX_W-1:0]];
  // More buffered bytes remain for the data phase
  assign more_data     = ({1'b0, byte_index_r} < {1'b0, write_fill_r}) &&
                         (byte_index_r < 5'(i2cm_pkg::WRITE_BUFFER_DEPTH));
  assign bc_in         = item.byte_count;

  // Next state for one accepted item
  always_comb begin
    phase_nxt      = phase_r;
    kind_nxt       = kind_r;
    sub_step_nxt   = sub_step_r;
    bit_index_nxt  = bit_index_r;
    byte_index_nxt = byte_index_r;
    shift_byte_nxt = shift_byte_r;
    tgt_addr_nxt   = tgt_addr_r;
    tgt_reg_nxt    = tgt_reg_r;
    read_total_nxt = read_total_r;
    write_fill_nxt = write_fill_r;
    wr_en          = 1'b0;
    rd_valid       = 1'b0;
    rd_data        = 8'd0;
    rd_last        = 1'b0;
    done           = 1'b0;
    stat           = 1'b0;

    if (accept) begin
      if (phase_r != i2cm_pkg::PH_IDLE) begin
        // Busy: only a tick advances the bus
        if (item.mode == i2cm_pkg::MODE_TICK) begin
          unique case (phase_r)
            i2cm_pkg::PH_START: begin
              if (sub_step_r == 2'd0) begin
                sub_step_nxt = 2'd1;
              end else begin
                sub_step_nxt  = 2'd0;
                bit_index_nxt = 4'd0;
                if (kind_r == i2cm_pkg::KIND_CUR_READ) begin
                  phase_nxt      = i2cm_pkg::PH_SEND_ADDRR;
                  shift_byte_nxt = {tgt_addr_r, 1'b0} | i2cm_pkg::ADDR_RD_BIT;
                end else begin
                  phase_nxt      = i2cm_pkg::PH_SEND_ADDRW;
                  shift_byte_nxt = {tgt_addr_r, 1'b0} & i2cm_pkg::ADDR_WR_MASK;
                end
              end
            end
            i2cm_pkg::PH_SEND_ADDRW, i2cm_pkg::PH_SEND_REG,
            i2cm_pkg::PH_SEND_DATA, i2cm_pkg::PH_SEND_ADDRR: begin
              if (sub_step_r == 2'd0) begin
                sub_step_nxt = 2'd1;
              end else begin
                sub_step_nxt = 2'd0;
                if (bit_index_r < 4'd8) begin
                  shift_byte_nxt = bit_shifted;
                  bit_index_nxt  = bit_index_r + 4'd1;
                end else if (item.sda_in) begin
                  // NACK from the target
                  phase_nxt     = i2cm_pkg::PH_STOP_ERR;
                  bit_index_nxt = 4'd0;
                end else begin
                  bit_index_nxt = 4'd0;
                  unique case (phase_r)
                    i2cm_pkg::PH_SEND_ADDRW: begin
                      phase_nxt      = i2cm_pkg::PH_SEND_REG;
                      shift_byte_nxt = tgt_reg_r;
                    end
                    i2cm_pkg::PH_SEND_REG: begin
                      if (kind_r == i2cm_pkg::KIND_WRITE) begin
                        if (write_fill_r != '0) begin
                          phase_nxt      = i2cm_pkg::PH_SEND_DATA;
                          shift_byte_nxt = wr_store_r[0];
                          byte_index_nxt = 5'd1;
                        end else begin
                          phase_nxt      = i2cm_pkg::PH_STOP_OK;
                          byte_index_nxt = 5'd0;
                        end
                      end else if (kind_r == i2cm_pkg::KIND_REG_READ) begin
                        phase_nxt     = i2cm_pkg::PH_RSTART;
                        bit_index_nxt = bit_index_r;
                      end else begin
                        phase_nxt = i2cm_pkg::PH_STOP_OK;
                      end
                    end
                    i2cm_pkg::PH_SEND_DATA: begin
                      if (more_data) begin
                        shift_byte_nxt = store_word;
                        byte_index_nxt = byte_plus_cur[4:0];
                      end else begin
                        phase_nxt = i2cm_pkg::PH_STOP_OK;
                      end
                    end
                    default: begin
                      phase_nxt      = i2cm_pkg::PH_RECV;
                      byte_index_nxt = 5'd0;
                      shift_byte_nxt = 8'd0;
                    end
                  endcase
                end
              end
            end
            i2cm_pkg::PH_RSTART: begin
              if (sub_step_r < 2'd2) begin
                sub_step_nxt = sub_step_r + 2'd1;
              end else begin
                phase_nxt      = i2cm_pkg::PH_SEND_ADDRR;
                shift_byte_nxt = {tgt_addr_r, 1'b0} | i2cm_pkg::ADDR_RD_BIT;
                bit_index_nxt  = 4'd0;
                sub_step_nxt   = 2'd0;
              end
            end
            i2cm_pkg::PH_RECV: begin
              if (sub_step_r == 2'd0) begin
                sub_step_nxt = 2'd1;
              end else begin
                sub_step_nxt = 2'd0;
                if (bit_index_r < 4'd8) begin
                  shift_byte_nxt = recv_shifted;
                  bit_index_nxt  = bit_index_r + 4'd1;
                  if (bit_index_r == 4'd7) begin
                    rd_valid = 1'b1;
                    rd_data  = recv_shifted;
                    rd_last  = last_cur;
                  end
                end else if (last_cur) begin
                  phase_nxt     = i2cm_pkg::PH_STOP_OK;
                  bit_index_nxt = 4'd0;
                end else begin
                  byte_index_nxt = byte_plus_cur[4:0];
                  bit_index_nxt  = 4'd0;
                  shift_byte_nxt = 8'd0;
                end
              end
            end
            i2cm_pkg::PH_STOP_OK, i2cm_pkg::PH_STOP_ERR: begin
              if (sub_step_r == 2'd0) begin
                sub_step_nxt = 2'd1;
              end else begin
                done = 1'b1;
                stat = (phase_r == i2cm_pkg::PH_STOP_ERR);
                if (kind_r == i2cm_pkg::KIND_WRITE) begin
                  write_fill_nxt = '0;
                end
                phase_nxt     = i2cm_pkg::PH_IDLE;
                sub_step_nxt  = 2'd0;
                bit_index_nxt = 4'd0;
              end
            end
            default: begin
              phase_nxt    = i2cm_pkg::PH_IDLE;
              sub_step_nxt = 2'd0;
            end
          endcase
        end
      end else begin
        // Idle: buffer pushes and transaction starts
        unique case (item.mode)
          i2cm_pkg::MODE_PUSH: begin
            if (write_fill_r < i2cm_pkg::BUF_FILL_W'(i2cm_pkg::WRITE_BUFFER_DEPTH)) begin
              wr_en          = 1'b1;
              write_fill_nxt = write_fill_r + i2cm_pkg::BUF_FILL_W'(1);
            end
          end
          i2cm_pkg::MODE_WRITE, i2cm_pkg::MODE_REG_READ, i2cm_pkg::MODE_CUR_READ: begin
            tgt_addr_nxt   = item.device_address;
            tgt_reg_nxt    = item.register_address;
            case (item.mode)
              i2cm_pkg::MODE_WRITE:    kind_nxt = i2cm_pkg::KIND_WRITE;
              i2cm_pkg::MODE_REG_READ: kind_nxt = i2cm_pkg::KIND_REG_READ;
              default:                 kind_nxt = i2cm_pkg::KIND_CUR_READ;
            endcase
            // Zero count reads one byte
            if (item.mode == i2cm_pkg::MODE_REG_READ && bc_in != 5'd0) begin
              read_total_nxt = bc_in;
            end else begin
              read_total_nxt = 5'd1;
            end
            byte_index_nxt = 5'd0;
            bit_index_nxt  = 4'd0;
            shift_byte_nxt = 8'd0;
            sub_step_nxt   = 2'd0;
            phase_nxt      = i2cm_pkg::PH_START;
          end
          default: ;
        endcase
      end
    end
  end

  // Bus levels after the item, from the updated state
  assign byte_plus_new = {1'b0, byte_index_nxt} + 6'd1;
  assign last_new      = byte_plus_new >= {1'b0, read_total_nxt};

  always_comb begin
    result            = '0;
    result.scl_level  = 1'b1;
    result.sda_level  = 1'b1;
    unique case (phase_nxt)
      i2cm_pkg::PH_START: begin
        result.sda_level = (sub_step_nxt == 2'd0);
      end
      i2cm_pkg::PH_SEND_ADDRW, i2cm_pkg::PH_SEND_REG,
      i2cm_pkg::PH_SEND_DATA, i2cm_pkg::PH_SEND_ADDRR: begin
        result.scl_level = sub_step_nxt[0];
        result.sda_level = (bit_index_nxt < 4'd8) ?
                           ((shift_byte_nxt & i2cm_pkg::BYTE_MSB) != 8'd0) : 1'b1;
      end
      i2cm_pkg::PH_RSTART: begin
        result.scl_level = (sub_step_nxt != 2'd0);
        result.sda_level = (sub_step_nxt != 2'd2);
      end
      i2cm_pkg::PH_RECV: begin
        result.scl_level = sub_step_nxt[0];
        result.sda_level = (bit_index_nxt < 4'd8) ? 1'b1 : last_new;
      end
      i2cm_pkg::PH_STOP_OK, i2cm_pkg::PH_STOP_ERR: begin
        result.scl_level = sub_step_nxt[0];
        result.sda_level = 1'b0;
      end
      default: ;
    endcase
    result.busy_res   = (phase_nxt != i2cm_pkg::PH_IDLE);
    result.read_valid = rd_valid;
    result.read_data  = rd_data;
    result.read_last  = rd_last;
    result.done_res   = done;
    result.status     = stat;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= i2cm_pkg::PH_IDLE;
      kind_r       <= i2cm_pkg::KIND_NONE;
      sub_step_r   <= 2'd0;
      bit_index_r  <= 4'd0;
      byte_index_r <= 5'd0;
      shift_byte_r <= 8'd0;
      tgt_addr_r   <= 7'd0;
      tgt_reg_r    <= 8'd0;
      read_total_r <= 5'd0;
      write_fill_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      kind_r       <= kind_nxt;
      sub_step_r   <= sub_step_nxt;
      bit_index_r  <= bit_index_nxt;
      byte_index_r <= byte_index_nxt;
      shift_byte_r <= shift_byte_nxt;
      tgt_addr_r   <= tgt_addr_nxt;
      tgt_reg_r    <= tgt_reg_nxt;
      read_total_r <= read_total_nxt;
      write_fill_r <= write_fill_nxt;
    end
  end

  // Write buffer, contents undefined until pushed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wr_store_r[write_fill_r[i2cm_pkg::BUF_IDX_W-1:0]] <= item.write_byte;
    end
  end

endmodule

`default_nettype wire

// ----- test/i2c_master_checker.sv -----
// Checker for the I2C master register access block: predicts every result item and compares.
module i2c_master_checker
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted sequencer state
  phase_t                bus_phase;
  logic [1:0]            half;
  logic [3:0]            bit_pos;
  logic [4:0]            byte_pos;
  logic [7:0]            shreg;
  kind_t                 xfer_kind;
  logic [6:0]            dev_addr;
  logic [7:0]            reg_addr;
  logic [4:0]            rd_total;
  logic [7:0]            wr_buf [WRITE_BUFFER_DEPTH];
  logic [BUF_FILL_W-1:0] wr_fill;

  // expected results, oldest first
  result_t     bus_expect_q[$];
  int unsigned mismatches = 0;

  function automatic logic rx_last_byte();
    return int'(byte_pos) + 1 >= int'(rd_total);
  endfunction

  // address byte with the R/W bit
  function automatic logic [7:0] addr_byte(input logic rd);
    logic [7:0] a;
    a = {1'b0, dev_addr} << 1;
    return rd ? (a | ADDR_RD_BIT) : (a & ADDR_WR_MASK);
  endfunction

  task automatic load_byte(input phase_t p, input logic [7:0] b);
    bus_phase = p;
    shreg     = b;
    bit_pos   = '0;
    half      = '0;
  endtask

  task automatic enter_stop(input phase_t p);
    bus_phase = p;
    half      = '0;
    bit_pos   = '0;
  endtask

  task automatic next_data_or_stop();
    if (byte_pos < wr_fill && byte_pos < WRITE_BUFFER_DEPTH) begin
      load_byte(PH_SEND_DATA, wr_buf[byte_pos[BUF_IDX_W-1:0]]);
      byte_pos++;
    end else begin
      enter_stop(PH_STOP_OK);
    end
  endtask

  // ACK slot of a byte the master sent: sda high is a NACK
  task automatic take_ack(input logic sda);
    if (sda) begin
      enter_stop(PH_STOP_ERR);
      return;
    end
    case (bus_phase)
      PH_SEND_ADDRW: load_byte(PH_SEND_REG, reg_addr);
      PH_SEND_REG: begin
        if (xfer_kind == KIND_WRITE) begin
          byte_pos = '0;
          next_data_or_stop();
        end else if (xfer_kind == KIND_REG_READ) begin
          bus_phase = PH_RSTART;
          half      = '0;
        end else begin
          enter_stop(PH_STOP_OK);
        end
      end
      PH_SEND_DATA: next_data_or_stop();
      default: begin
        bus_phase = PH_RECV;
        byte_pos  = '0;
        bit_pos   = '0;
        shreg     = '0;
        half      = '0;
      end
    endcase
  endtask

  // one half-bit interval
  task automatic advance_bus(input logic sda, inout result_t r);
    case (bus_phase)
      PH_START: begin
        if (half == 0) half = 1;
        else if (xfer_kind == KIND_CUR_READ) load_byte(PH_SEND_ADDRR, addr_byte(1'b1));
        else load_byte(PH_SEND_ADDRW, addr_byte(1'b0));
      end
      PH_SEND_ADDRW, PH_SEND_REG, PH_SEND_DATA, PH_SEND_ADDRR: begin
        if (half == 0) begin
          half = 1;
        end else begin
          half = 0;
          if (bit_pos < 8) begin
            shreg = {shreg[6:0], 1'b0};
            bit_pos++;
          end else begin
            take_ack(sda);
          end
        end
      end
      PH_RSTART: begin
        if (half < 2) half++;
        else load_byte(PH_SEND_ADDRR, addr_byte(1'b1));
      end
      PH_RECV: begin
        if (half == 0) begin
          half = 1;
        end else begin
          half = 0;
          if (bit_pos < 8) begin
            shreg = {shreg[6:0], sda};
            bit_pos++;
            if (bit_pos == 8) begin
              r.read_valid = 1'b1;
              r.read_data  = shreg;
              r.read_last  = rx_last_byte();
            end
          end else if (rx_last_byte()) begin
            enter_stop(PH_STOP_OK);
          end else begin
            byte_pos++;
            bit_pos = '0;
            shreg   = '0;
          end
        end
      end
      PH_STOP_OK, PH_STOP_ERR: begin
        if (half == 0) begin
          half = 1;
        end else begin
          r.done_res = 1'b1;
          r.status   = (bus_phase == PH_STOP_ERR);
          if (xfer_kind == KIND_WRITE) wr_fill = '0;
          bus_phase = PH_IDLE;
          half      = '0;
          bit_pos   = '0;
        end
      end
      default: begin
        bus_phase = PH_IDLE;
        half      = '0;
      end
    endcase
  endtask

  task automatic predict_bus_item(input item_t it, output result_t r);
    r = '0;
    if (bus_phase != PH_IDLE) begin
      // commands while busy are dropped, only ticks move the bus
      if (it.mode == MODE_TICK) advance_bus(it.sda_in, r);
    end else if (it.mode == MODE_PUSH) begin
      if (wr_fill < WRITE_BUFFER_DEPTH) begin
        wr_buf[wr_fill[BUF_IDX_W-1:0]] = it.write_byte;
        wr_fill++;
      end
    end else if (it.mode inside {MODE_WRITE, MODE_REG_READ, MODE_CUR_READ}) begin
      dev_addr = it.device_address;
      reg_addr = it.register_address;
      if (it.mode == MODE_WRITE) xfer_kind = KIND_WRITE;
      else if (it.mode == MODE_REG_READ) xfer_kind = KIND_REG_READ;
      else xfer_kind = KIND_CUR_READ;
      rd_total  = (it.mode == MODE_REG_READ && it.byte_count != 0) ? it.byte_count : 5'd1;
      byte_pos  = '0;
      bit_pos   = '0;
      shreg     = '0;
      half      = '0;
      bus_phase = PH_START;
    end

    // bus levels after the item
    r.scl_level = 1'b1;
    r.sda_level = 1'b1;
    case (bus_phase)
      PH_START: r.sda_level = (half == 0);
      PH_SEND_ADDRW, PH_SEND_REG, PH_SEND_DATA, PH_SEND_ADDRR: begin
        r.scl_level = half[0];
        r.sda_level = (bit_pos < 8) ? ((shreg & BYTE_MSB) != 0) : 1'b1;
      end
      PH_RSTART: begin
        r.scl_level = (half != 0);
        r.sda_level = (half != 2);
      end
      PH_RECV: begin
        r.scl_level = half[0];
        r.sda_level = (bit_pos < 8) ? 1'b1 : rx_last_byte();
      end
      PH_STOP_OK, PH_STOP_ERR: begin
        r.scl_level = half[0];
        r.sda_level = 1'b0;
      end
      default: ;
    endcase
    r.busy_res = (bus_phase != PH_IDLE);
  endtask

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // results are retired before the new item is predicted
  always @(posedge clk) begin
    item_t   it;
    result_t want;
    result_t got;
    if (!rst_n) begin
      bus_phase = PH_IDLE;
      half      = '0;
      bit_pos   = '0;
      byte_pos  = '0;
      shreg     = '0;
      xfer_kind = KIND_NONE;
      dev_addr  = '0;
      reg_addr  = '0;
      rd_total  = '0;
      wr_fill   = '0;
      bus_expect_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.scl_level  = out_tdata[0];
        got.sda_level  = out_tdata[1];
        got.busy_res   = out_tdata[2];
        got.read_valid = out_tdata[3];
        got.read_data  = out_tdata[11:4];
        got.done_res   = out_tdata[12];
        got.status     = out_tdata[13];
        got.read_last  = out_tlast;
        if (bus_expect_q.size() == 0) begin
          $error("result item arrived with nothing expected");
          mismatches++;
        end else begin
          want = bus_expect_q.pop_front();
          check_field("scl_level", want.scl_level, got.scl_level);
          check_field("sda_level", want.sda_level, got.sda_level);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("read_valid", want.read_valid, got.read_valid);
          check_field("read_data", want.read_data, got.read_data);
          check_field("read_last", want.read_last, got.read_last);
          check_field("done_res", want.done_res, got.done_res);
          check_field("status", want.status, got.status);
        end
      end
      if (in_tvalid && in_tready) begin
        it.mode             = in_tuser;
        it.device_address   = in_tdata[6:0];
        it.register_address = in_tdata[14:7];
        it.byte_count       = in_tdata[19:15];
        it.write_byte       = in_tdata[27:20];
        it.sda_in           = in_tdata[28];
        predict_bus_item(it, want);
        bus_expect_q.push_back(want);
      end
    end
    fail_count <= mismatches;
    pending    <= bus_expect_q.size();
  end

endmodule

// ----- test/tb.sv -----
// Testbench top for the I2C master register access block: stimulus, flow control and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  // modes outside the opcode set, ignored by the block
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0]  in_tuser = MODE_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  int unsigned fail_count;
  int unsigned pending;

  // stimulus bookkeeping
  bit calm = 1'b1;
  int noise_pct = 0;
  int buf_fill = 0;
  int n_items = 0;
  int n_writes = 0;
  int n_reg_reads = 0;
  int n_cur_reads = 0;
  int n_nacks = 0;
  int n_rx = 0;

  i2c_master_register_access_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  i2c_master_checker i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side back-pressure
  initial begin
    int span;
    forever begin
      span = $urandom_range(1, 12);
      out_tready <= 1'b1;
      repeat (span) @(posedge clk);
      span = idle_len();
      if (span > 0) begin
        out_tready <= 1'b0;
        repeat (span) @(posedge clk);
      end
    end
  end

  // drive one item and hold it until accepted
  task automatic send(input logic [2:0] mode, input logic [6:0] dev, input logic [7:0] regad,
                      input logic [4:0] cnt, input logic [7:0] wb, input logic sda,
                      input bit counts);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {3'b000, sda, wb, cnt, regad, dev};
    do @(posedge clk); while (!in_tready);
    if (counts) n_items++;
  endtask

  // bus tick, now and then preceded by a command the busy block must drop
  task automatic tick(input logic sda);
    if (!calm && $urandom_range(0, 99) < noise_pct)
      send(3'($urandom_range(MODE_PUSH, MODE_UNUSED_HI)), 7'($urandom), 8'($urandom),
           5'($urandom), 8'($urandom), 1'($urandom), 1'b0);
    send(MODE_TICK, 7'($urandom), 8'($urandom), 5'($urandom), 8'($urandom), sda, 1'b1);
  endtask

  // one transaction: pushes, command, then ticks scripted so ACKs land on their slots;
  // nack_at picks the master-sent byte that gets a NACK, scramble randomizes every ACK
  task automatic run_xfer(input mode_t cmd, input int n_push, input logic [6:0] dev,
                          input logic [7:0] regad, input logic [4:0] cnt, input int nack_at,
                          input bit scramble);
    int sent;
    int n_rx_bytes;
    logic nacked;
    nacked = 1'b0;
    for (int i = 0; i < n_push; i++) begin
      send(MODE_PUSH, 7'($urandom), 8'($urandom), 5'($urandom),
           (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom), 1'($urandom), 1'b1);
      if (buf_fill < WRITE_BUFFER_DEPTH) buf_fill++;
    end
    send(cmd, dev, regad, cnt, 8'($urandom), 1'($urandom), 1'b1);
    case (cmd)
      MODE_WRITE: begin
        sent = 2 + buf_fill;
        n_rx_bytes = 0;
        n_writes++;
        buf_fill = 0;
      end
      MODE_REG_READ: begin
        sent = 3;
        n_rx_bytes = (cnt == 0) ? 1 : cnt;
        n_reg_reads++;
      end
      default: begin
        sent = 1;
        n_rx_bytes = 1;
        n_cur_reads++;
      end
    endcase
    // START
    repeat (2) tick(1'($urandom));
    // bytes from the master, repeated START before the read address
    for (int b = 0; b < sent; b++) begin
      if (cmd == MODE_REG_READ && b == 2) repeat (3) tick(1'($urandom));
      repeat (17) tick(1'($urandom));
      nacked = scramble ? 1'($urandom) : (b == nack_at);
      tick(nacked);
      if (nacked) break;
    end
    if (nacked) begin
      n_nacks++;
    end else begin
      repeat (n_rx_bytes * 18) tick(1'($urandom));
      n_rx += n_rx_bytes;
    end
    // STOP, then a little idle bus with plain ticks only
    repeat (2) tick(1'($urandom));
    repeat ($urandom_range(0, 2))
      send(MODE_TICK, 7'($urandom), 8'($urandom), 5'($urandom), 8'($urandom),
           1'($urandom), 1'b1);
  endtask

  // sender holds off until every expected result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    mode_t cmd;
    int n_push;
    int nack_at;
    logic [4:0] cnt;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, unused modes, buffer overflow, write aborted on its address
    send(MODE_TICK, '1, '1, '1, '1, 1'b1, 1'b1);
    send(MODE_UNUSED_HI, '1, '1, '1, '1, 1'b1, 1'b0);
    send(MODE_UNUSED_LO, '0, '0, '0, '0, 1'b0, 1'b0);
    run_xfer(MODE_WRITE, WRITE_BUFFER_DEPTH + 1, 7'h00, 8'hFF, 5'd0, 0, 1'b0);
    drain();

    // random transactions, mostly well formed
    noise_pct = 6;
    while (n_items < 550) begin
      calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 40) cmd = MODE_REG_READ;
      else if (r < 70) cmd = MODE_WRITE;
      else cmd = MODE_CUR_READ;
      if (cmd == MODE_WRITE)
        n_push = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 3);
      else
        n_push = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      if (cmd == MODE_REG_READ)
        cnt = ($urandom_range(0, 9) == 0) ? 5'd16 : 5'($urandom_range(0, 4));
      else
        cnt = 5'($urandom);
      nack_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : -1;
      run_xfer(cmd, n_push, 7'($urandom), 8'($urandom), cnt, nack_at,
               $urandom_range(0, 9) == 0);
      if ($urandom_range(0, 4) == 0) drain();
    end

    drain();
    repeat (5) @(posedge clk);
    $display("Covered %0d items: %0d register writes, %0d register reads, %0d current reads.",
             n_items, n_writes, n_reg_reads, n_cur_reads);
    $display("%0d transactions ended on a NACK, %0d bytes read from the target.",
             n_nacks, n_rx);
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
